### src/psr_pkg.sv
// Shared widths, defaults and types for the polyline segment resampler.
`default_nettype none

package psr_pkg;

    localparam int COORD_W         = 24;
    localparam int SPACING_W       = 23;
    localparam int MAG_W           = COORD_W + 1;
    localparam int CNT_W           = 6;
    localparam int SPAN_W          = 29;
    localparam int PROD_W          = 2 * SPAN_W;
    localparam int D2_W            = 2 * MAG_W;
    localparam int DEF_SPACING     = 25600;
    localparam int DEF_MAX_SAMPLES = 63;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quo;
        logic [CNT_W-1:0] rem;
    } div_stat_t;

endpackage

`default_nettype wire

### src/psr_ifs.sv
// Valid/ready channel interfaces for vertices, resampled points and configuration.
`default_nettype none

interface psr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [psr_pkg::COORD_W-1:0]  point_x;
    logic signed [psr_pkg::COORD_W-1:0]  point_y;
    logic signed [psr_pkg::COORD_W-1:0]  point_z;
    logic                                final_vertex;
    modport source (output valid, point_x, point_y, point_z, final_vertex, input ready);
    modport sink (input valid, point_x, point_y, point_z, final_vertex, output ready);
endinterface

interface psr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [psr_pkg::COORD_W-1:0]  out_x;
    logic signed [psr_pkg::COORD_W-1:0]  out_y;
    logic signed [psr_pkg::COORD_W-1:0]  out_z;
    logic                                run_last;
    logic                                line_end;
    modport source (output valid, out_x, out_y, out_z, run_last, line_end, input ready);
    modport sink (input valid, out_x, out_y, out_z, run_last, line_end, output ready);
endinterface

interface psr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [psr_pkg::SPACING_W-1:0]     data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### src/psr_div.sv
// Bit-serial restoring divider of a coordinate magnitude by the sample count.
`default_nettype none

module psr_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [psr_pkg::MAG_W-1:0]   dividend,
    input  wire logic [psr_pkg::CNT_W-1:0]   divisor,
    output psr_pkg::div_stat_t               stat
);

    localparam int STEP_W = $clog2(psr_pkg::MAG_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [psr_pkg::CNT_W-1:0]   dvs_reg;
    logic [psr_pkg::CNT_W-1:0]   rem_reg;
    logic [psr_pkg::MAG_W-1:0]   quo_reg;
    logic [psr_pkg::CNT_W:0]     trial;
    logic                        ge;

    assign trial = {rem_reg, quo_reg[psr_pkg::MAG_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(psr_pkg::MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? psr_pkg::CNT_W'(trial - {1'b0, dvs_reg})
                          : psr_pkg::CNT_W'(trial);
            quo_reg <= {quo_reg[psr_pkg::MAG_W-2:0], ge};
        end
    end

    assign stat.done = done_reg;
    assign stat.quo  = quo_reg;
    assign stat.rem  = rem_reg;

endmodule

`default_nettype wire

### src/polyline_segment_resampler.sv
// Top level of the polyline segment resampler: sequencer, shared squarer and output register.
//
// Vertices arrive on pt_in, resampled points leave on pt_out, and cfg writes the
// target spacing (zero selects DEFAULT_SPACING). The block handles one vertex at a
// time; pt_in.ready is high only while it is idle.
// A first vertex that is not final is stored and gives no point; a lone final vertex
// gives one point. A vertex that closes a segment goes through difference and
// squaring, then tries sample counts one by one on the shared squarer (up to
// MAX_SAMPLES-1 tries), then, for n >= 2, runs three serial divisions, one per axis.
// After that the start point and the n-1 interior points are emitted, and a final
// vertex adds one more point. Each interior point steps a quotient/remainder
// accumulator, so no division runs per point.
// A single output register holds each point; while the receiver stalls the
// sequencer waits and loads the next point in the cycle the current one is taken.
// Reset clears the stored vertex, sets the spacing to 25600 and empties the output.
`default_nettype none

module polyline_segment_resampler #(
    parameter int unsigned DEFAULT_SPACING = psr_pkg::DEF_SPACING,
    parameter int unsigned MAX_SAMPLES     = psr_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    psr_in_if.sink     pt_in,
    psr_out_if.source  pt_out,
    psr_cfg_if.sink    cfg
);

    localparam int CW = psr_pkg::COORD_W;
    localparam int MW = psr_pkg::MAG_W;
    localparam int NW = psr_pkg::CNT_W;
    localparam int SW = psr_pkg::SPAN_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_SAMPLES);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIFF  = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_SMUL  = 4'd3;
    localparam logic [3:0] ST_SCMP  = 4'd4;
    localparam logic [3:0] ST_DIVGO = 4'd5;
    localparam logic [3:0] ST_DIVW  = 4'd6;
    localparam logic [3:0] ST_EMIT0 = 4'd7;
    localparam logic [3:0] ST_ADV   = 4'd8;
    localparam logic [3:0] ST_EMITJ = 4'd9;
    localparam logic [3:0] ST_EMITF = 4'd10;

    logic [3:0]                  state_reg;
    logic [psr_pkg::SPACING_W-1:0] spacing_reg;
    logic [CW-1:0]               cur_reg [3];
    logic                        fin_reg;
    logic [CW-1:0]               prev_reg [3];
    logic                        have_prev_reg;
    logic [MW-1:0]               mag_reg [3];
    logic                        neg_reg [3];
    logic [1:0]                  c_reg;
    logic [psr_pkg::D2_W-1:0]    d2_reg;
    logic [psr_pkg::PROD_W-1:0]  prod_reg;
    logic [SW-1:0]               s_reg;
    logic [NW-1:0]               n_reg;
    logic [NW-1:0]               j_reg;
    logic [MW-1:0]               quo_reg [3];
    logic [NW-1:0]               rem_reg [3];
    logic [MW-1:0]               acc_q_reg [3];
    logic [NW-1:0]               acc_r_reg [3];
    logic                        ov_reg;
    logic [CW-1:0]               o_reg [3];
    logic                        o_last_reg;
    logic                        o_end_reg;

    logic [SW-1:0]               spacing_eff;
    logic [MW-1:0]               mag_sel;
    logic [SW-1:0]               mul_a;
    logic [psr_pkg::PROD_W-1:0]  prod;
    logic                        can_load;
    logic                        last_j;
    logic [MW-1:0]               diff [3];
    logic [NW:0]                 r_sum [3];
    logic                        r_ge [3];
    logic [MW-1:0]               off [3];
    logic [CW-1:0]               pt [3];
    logic                        div_start;
    psr_pkg::div_stat_t          div_stat;

    assign spacing_eff = (spacing_reg == '0) ? SW'(DEFAULT_SPACING) : SW'(spacing_reg);
    assign can_load    = !ov_reg || pt_out.ready;
    assign last_j      = (j_reg == n_reg - 1'b1);
    assign div_start   = (state_reg == ST_DIVGO);

    always_comb
    begin
        case (c_reg)
            2'd0:    mag_sel = mag_reg[0];
            2'd1:    mag_sel = mag_reg[1];
            2'd2:    mag_sel = mag_reg[2];
            default: mag_sel = '0;
        endcase
    end

    assign mul_a = (state_reg == ST_SQ) ? SW'(mag_sel) : s_reg;
    assign prod  = psr_pkg::PROD_W'(mul_a) * psr_pkg::PROD_W'(mul_a);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k]  = {cur_reg[k][CW-1], cur_reg[k]} - {prev_reg[k][CW-1], prev_reg[k]};
            r_sum[k] = {1'b0, acc_r_reg[k]} + {1'b0, rem_reg[k]};
            r_ge[k]  = r_sum[k] >= {1'b0, n_reg};
            off[k]   = neg_reg[k] ? (~acc_q_reg[k] + 1'b1) : acc_q_reg[k];
            pt[k]    = prev_reg[k] + off[k][CW-1:0];
        end
    end

    psr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_sel),
        .divisor  (n_reg),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spacing_reg   <= psr_pkg::SPACING_W'(psr_pkg::DEF_SPACING);
            have_prev_reg <= 1'b0;
            ov_reg        <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                prev_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                spacing_reg <= cfg.data;
            end
            if (ov_reg && pt_out.ready)
            begin
                ov_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (pt_in.valid)
                    begin
                        if (have_prev_reg)
                        begin
                            state_reg <= ST_DIFF;
                        end
                        else if (pt_in.final_vertex)
                        begin
                            state_reg <= ST_EMITF;
                        end
                        else
                        begin
                            prev_reg[0]   <= pt_in.point_x;
                            prev_reg[1]   <= pt_in.point_y;
                            prev_reg[2]   <= pt_in.point_z;
                            have_prev_reg <= 1'b1;
                        end
                    end
                end
                ST_DIFF:
                begin
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (c_reg == 2'd3)
                    begin
                        if (d2_reg + prod_reg == '0)
                        begin
                            state_reg <= ST_EMIT0;
                        end
                        else if (MAX_N == NW'(1))
                        begin
                            state_reg <= ST_EMIT0;
                        end
                        else
                        begin
                            state_reg <= ST_SMUL;
                        end
                    end
                end
                ST_SMUL:
                begin
                    state_reg <= ST_SCMP;
                end
                ST_SCMP:
                begin
                    if (prod_reg >= psr_pkg::PROD_W'(d2_reg) || n_reg == MAX_N - 1'b1)
                    begin
                        state_reg <= (prod_reg >= psr_pkg::PROD_W'(d2_reg) &&
                                      n_reg == NW'(1)) ? ST_EMIT0 : ST_DIVGO;
                    end
                    else
                    begin
                        state_reg <= ST_SMUL;
                    end
                end
                ST_DIVGO:
                begin
                    state_reg <= ST_DIVW;
                end
                ST_DIVW:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= (c_reg == 2'd2) ? ST_EMIT0 : ST_DIVGO;
                    end
                end
                ST_EMIT0:
                begin
                    if (can_load)
                    begin
                        ov_reg <= 1'b1;
                        if (n_reg >= NW'(2))
                        begin
                            state_reg <= ST_ADV;
                        end
                        else if (fin_reg)
                        begin
                            state_reg <= ST_EMITF;
                        end
                        else
                        begin
                            prev_reg      <= cur_reg;
                            have_prev_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                ST_ADV:
                begin
                    state_reg <= ST_EMITJ;
                end
                ST_EMITJ:
                begin
                    if (can_load)
                    begin
                        ov_reg <= 1'b1;
                        if (!last_j)
                        begin
                            state_reg <= ST_ADV;
                        end
                        else if (fin_reg)
                        begin
                            state_reg <= ST_EMITF;
                        end
                        else
                        begin
                            prev_reg      <= cur_reg;
                            have_prev_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                ST_EMITF:
                begin
                    if (can_load)
                    begin
                        ov_reg        <= 1'b1;
                        have_prev_reg <= 1'b0;
                        for (int k = 0; k < 3; k++)
                        begin
                            prev_reg[k] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers; every value here is rebuilt for each vertex before use.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg[0] <= pt_in.point_x;
                cur_reg[1] <= pt_in.point_y;
                cur_reg[2] <= pt_in.point_z;
                fin_reg    <= pt_in.final_vertex;
                n_reg      <= '0;
            end
            ST_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[k] <= diff[k][MW-1];
                    mag_reg[k] <= diff[k][MW-1] ? (~diff[k] + 1'b1) : diff[k];
                end
                c_reg  <= 2'd0;
                d2_reg <= '0;
            end
            ST_SQ:
            begin
                // The squarer output is registered, so the sum trails by one axis.
                if (c_reg != 2'd0)
                begin
                    d2_reg <= d2_reg + psr_pkg::D2_W'(prod_reg);
                end
                c_reg <= c_reg + 1'b1;
                if (c_reg == 2'd3)
                begin
                    n_reg <= (d2_reg + psr_pkg::D2_W'(prod_reg) == '0) ? NW'(0) : NW'(1);
                    s_reg <= spacing_eff;
                end
            end
            ST_SCMP:
            begin
                c_reg <= 2'd0;
                if (prod_reg >= psr_pkg::PROD_W'(d2_reg))
                begin
                    n_reg <= n_reg;
                end
                else if (n_reg == MAX_N - 1'b1)
                begin
                    n_reg <= MAX_N;
                end
                else
                begin
                    n_reg <= n_reg + 1'b1;
                    s_reg <= s_reg + spacing_eff;
                end
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    quo_reg[c_reg] <= div_stat.quo;
                    rem_reg[c_reg] <= div_stat.rem;
                    c_reg          <= c_reg + 1'b1;
                end
            end
            ST_EMIT0:
            begin
                if (can_load)
                begin
                    o_reg      <= prev_reg;
                    o_last_reg <= !fin_reg && (n_reg <= NW'(1));
                    o_end_reg  <= 1'b0;
                    j_reg      <= NW'(1);
                    for (int k = 0; k < 3; k++)
                    begin
                        acc_q_reg[k] <= '0;
                        acc_r_reg[k] <= '0;
                    end
                end
            end
            ST_ADV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    acc_q_reg[k] <= acc_q_reg[k] + quo_reg[k] + MW'(r_ge[k]);
                    acc_r_reg[k] <= r_ge[k] ? NW'(r_sum[k] - {1'b0, n_reg}) : NW'(r_sum[k]);
                end
            end
            ST_EMITJ:
            begin
                if (can_load)
                begin
                    o_reg      <= pt;
                    o_last_reg <= !fin_reg && last_j;
                    o_end_reg  <= 1'b0;
                    j_reg      <= j_reg + 1'b1;
                end
            end
            ST_EMITF:
            begin
                if (can_load)
                begin
                    o_reg      <= cur_reg;
                    o_last_reg <= 1'b1;
                    o_end_reg  <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pt_in.ready     = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign pt_out.valid    = ov_reg;
    assign pt_out.out_x    = o_reg[0];
    assign pt_out.out_y    = o_reg[1];
    assign pt_out.out_z    = o_reg[2];
    assign pt_out.run_last = o_last_reg;
    assign pt_out.line_end = o_end_reg;

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid && pt_out.line_end |-> pt_out.run_last)
        else $error("line end without run_last");

    a_n_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_N)
        else $error("sample count above limit");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMITF) && can_load |=> !have_prev_reg && pt_out.valid)
        else $error("final vertex did not clear stored vertex");

    a_div_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIVW)
        else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

### tb/psr_checker.sv
// Checker for the polyline segment resampler: predicts points from vertex transactions and compares.
`timescale 1ns / 100ps

module psr_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    psr_in_if.sink    pt_in,
    psr_out_if.sink   pt_out,
    psr_cfg_if.sink   cfg,
    output int        fail_count,
    output int        pending_points,
    output int        points_seen,
    output int        max_run
);

    typedef struct packed {
        logic signed [psr_pkg::COORD_W-1:0] x;
        logic signed [psr_pkg::COORD_W-1:0] y;
        logic signed [psr_pkg::COORD_W-1:0] z;
        logic                               run_last;
        logic                               line_end;
    } point_t;

    point_t             expected_points[$];
    logic [psr_pkg::SPACING_W-1:0] spacing_reg;
    longint             last_x, last_y, last_z;
    bit                 vertex_held;

    // Smallest count whose span covers the segment, found by comparing squares.
    function automatic int count_samples(longint d2, longint spc);
        longint s;
        if (d2 == 0)
            return 0;
        for (int n = 1; n < psr_pkg::DEF_MAX_SAMPLES; n++)
        begin
            s = n * spc;
            if (s * s >= d2)
                return n;
        end
        return psr_pkg::DEF_MAX_SAMPLES;
    endfunction

    function automatic point_t make_point(longint x, longint y, longint z, bit rl, bit le);
        point_t p;
        p.x = x[psr_pkg::COORD_W-1:0];
        p.y = y[psr_pkg::COORD_W-1:0];
        p.z = z[psr_pkg::COORD_W-1:0];
        p.run_last = rl;
        p.line_end = le;
        return p;
    endfunction

    task automatic predict_vertex(longint x, longint y, longint z, bit fin);
        longint dx, dy, dz, spc;
        int     n, k;
        k = 0;
        if (vertex_held)
        begin
            spc = (spacing_reg != 0) ? longint'(spacing_reg) : longint'(psr_pkg::DEF_SPACING);
            dx = x - last_x;
            dy = y - last_y;
            dz = z - last_z;
            n = count_samples(dx * dx + dy * dy + dz * dz, spc);
            expected_points.push_back(make_point(last_x, last_y, last_z, !fin && n <= 1, 0));
            k++;
            for (int j = 1; j < n; j++)
            begin
                // SystemVerilog integer division truncates toward zero.
                expected_points.push_back(make_point(last_x + (dx * j) / n,
                    last_y + (dy * j) / n, last_z + (dz * j) / n, !fin && j == n - 1, 0));
                k++;
            end
        end
        if (fin)
        begin
            expected_points.push_back(make_point(x, y, z, 1, 1));
            k++;
            vertex_held = 0;
            last_x = 0;
            last_y = 0;
            last_z = 0;
        end
        else
        begin
            vertex_held = 1;
            last_x = x;
            last_y = y;
            last_z = z;
        end
        if (k > max_run)
            max_run = k;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_t exp_p;
        if (!rst_n)
        begin
            spacing_reg = psr_pkg::SPACING_W'(psr_pkg::DEF_SPACING);
            vertex_held = 0;
            last_x = 0;
            last_y = 0;
            last_z = 0;
            expected_points.delete();
            fail_count = 0;
            points_seen = 0;
            max_run = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                spacing_reg = cfg.data;
            if (pt_out.valid && pt_out.ready)
            begin
                points_seen++;
                if (expected_points.size() == 0)
                begin
                    $error("unexpected point transaction x=%0d", pt_out.out_x);
                    fail_count++;
                end
                else
                begin
                    exp_p = expected_points.pop_front();
                    if (pt_out.out_x !== exp_p.x)
                    begin
                        $error("out_x expected %0d actual %0d", exp_p.x, pt_out.out_x);
                        fail_count++;
                    end
                    if (pt_out.out_y !== exp_p.y)
                    begin
                        $error("out_y expected %0d actual %0d", exp_p.y, pt_out.out_y);
                        fail_count++;
                    end
                    if (pt_out.out_z !== exp_p.z)
                    begin
                        $error("out_z expected %0d actual %0d", exp_p.z, pt_out.out_z);
                        fail_count++;
                    end
                    if (pt_out.run_last !== exp_p.run_last)
                    begin
                        $error("run_last expected %0b actual %0b", exp_p.run_last,
                               pt_out.run_last);
                        fail_count++;
                    end
                    if (pt_out.line_end !== exp_p.line_end)
                    begin
                        $error("line_end expected %0b actual %0b", exp_p.line_end,
                               pt_out.line_end);
                        fail_count++;
                    end
                end
            end
            if (pt_in.valid && pt_in.ready)
                predict_vertex(longint'(pt_in.point_x), longint'(pt_in.point_y),
                               longint'(pt_in.point_z), pt_in.final_vertex);
        end
        pending_points = expected_points.size();
    end

endmodule

### tb/polyline_segment_resampler_tb.sv
// Testbench top for the polyline segment resampler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module polyline_segment_resampler_tb;

    localparam int CYCLE_LIMIT = 900000;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count, pending_points, points_seen, max_run;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   recv_hold = 0;
    int   vertices_sent = 0;

    psr_in_if  pt_in();
    psr_out_if pt_out();
    psr_cfg_if cfg();

    polyline_segment_resampler u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pt_in (pt_in),
        .pt_out(pt_out),
        .cfg   (cfg)
    );

    psr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pt_in         (pt_in),
        .pt_out        (pt_out),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .pending_points(pending_points),
        .points_seen   (points_seen),
        .max_run       (max_run)
    );

    always #5 clk = ~clk;

    initial
    begin
        pt_in.valid = 0;
        pt_in.point_x = 0;
        pt_in.point_y = 0;
        pt_in.point_z = 0;
        pt_in.final_vertex = 0;
        pt_out.ready = 0;
        cfg.valid = 0;
        cfg.data = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("polyline_segment_resampler_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
        pt_out.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    // Valid stays high after the transaction so that vertices can follow back to back;
    // callers drop it once a sequence is done.
    task automatic send_vertex(logic signed [psr_pkg::COORD_W-1:0] x,
                               logic signed [psr_pkg::COORD_W-1:0] y,
                               logic signed [psr_pkg::COORD_W-1:0] z, bit fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pt_in.valid <= 0;
            @(posedge clk);
        end
        pt_in.valid <= 1;
        pt_in.point_x <= x;
        pt_in.point_y <= y;
        pt_in.point_z <= z;
        pt_in.final_vertex <= fin;
        @(posedge clk);
        while (!pt_in.ready)
            @(posedge clk);
        vertices_sent++;
    endtask

    task automatic drain_points();
        while (pending_points != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_spacing(logic [psr_pkg::SPACING_W-1:0] value);
        cfg.valid <= 1;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 0;
        @(posedge clk);
    endtask

    function automatic logic signed [psr_pkg::COORD_W-1:0] rand_coord(int span);
        if (span == 0)
            return psr_pkg::COORD_W'($urandom);
        return psr_pkg::COORD_W'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Random polylines of a few vertices, mostly short segments, some huge ones.
    task automatic random_polylines(int count, int span);
        logic signed [psr_pkg::COORD_W-1:0] x, y, z;
        int left, len;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(5, 1);
            x = rand_coord(span);
            y = rand_coord(span);
            z = rand_coord(span);
            for (int i = 0; i < len && left > 0; i++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    x = rand_coord(0);
                    y = rand_coord(0);
                    z = rand_coord(0);
                end
                else if ($urandom_range(7) == 0)
                    ;
                else
                begin
                    x = x + rand_coord(span);
                    y = y + rand_coord(span);
                    z = z + rand_coord(span / 2);
                end
                left--;
                send_vertex(x, y, z, i == len - 1 || left == 0);
            end
        end
        pt_in.valid <= 0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: lone final, zero length, extremes, saturation, default spacing.
        send_vertex(24'sd100, -24'sd100, 24'sd7, 1);
        send_vertex(24'sd5, 24'sd5, 24'sd5, 0);
        send_vertex(24'sd5, 24'sd5, 24'sd5, 0);
        send_vertex(24'sd25605, 24'sd5, 24'sd5, 0);
        send_vertex(24'sd80000, -24'sd30000, 24'sd12345, 1);
        send_vertex(-24'sd8388608, -24'sd8388608, -24'sd8388608, 0);
        send_vertex(24'sd8388607, 24'sd8388607, 24'sd8388607, 0);
        send_vertex(-24'sd8388608, 24'sd0, 24'sd8388607, 1);
        pt_in.valid <= 0;
        drain_points();
        write_spacing(23'd0);
        send_vertex(24'sd0, 24'sd0, 24'sd0, 0);
        send_vertex(24'sd51200, 24'sd0, 24'sd0, 0);
        send_vertex(24'sd51201, -24'sd1, 24'sd1, 1);
        pt_in.valid <= 0;
        drain_points();
        write_spacing(23'd1);
        send_vertex(24'sd0, 24'sd0, 24'sd0, 0);
        send_vertex(24'sd62, 24'sd0, -24'sd1, 0);
        send_vertex(-24'sd5, 24'sd3, 24'sd0, 1);
        pt_in.valid <= 0;
        drain_points();
        write_spacing(23'h7FFFFF);
        send_vertex(24'sd8388607, 24'sd0, 24'sd0, 0);
        send_vertex(-24'sd8388608, 24'sd0, 24'sd0, 1);
        pt_in.valid <= 0;
        drain_points();

        // Receiver holds off for a long stretch while vertices keep coming.
        write_spacing(23'd3000);
        recv_hold = 1;
        fork
            random_polylines(8, 20000);
            begin
                repeat (600) @(posedge clk);
                recv_hold = 0;
            end
        join
        drain_points();

        send_idle_pct = 16;
        recv_idle_pct = 60;
        write_spacing(23'd5000);
        random_polylines(50, 30000);
        drain_points();
        send_idle_pct = 60;
        recv_idle_pct = 16;
        write_spacing(23'd25600);
        random_polylines(50, 100000);
        drain_points();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_spacing(23'd700);
        random_polylines(50, 8000);
        drain_points();

        $display("Covered %0d vertices and %0d points, longest run %0d points,",
                 vertices_sent, points_seen, max_run);
        $display("across spacings from zero to full scale and three stall patterns.");
        if (fail_count == 0)
            $display("polyline_segment_resampler_tb OK");
        else
            $display("polyline_segment_resampler_tb NOT OK");
        $finish;
    end

endmodule

### polyline_segment_resampler.f
src/psr_pkg.sv
src/psr_ifs.sv
src/psr_div.sv
src/polyline_segment_resampler.sv
tb/psr_checker.sv
tb/polyline_segment_resampler_tb.sv
